@@ hdl/ddodo_pkg.sv @@
// ----------------------------------------------------------------------------
// ddodo_pkg: shared types, constants and helpers of the odometry unit
// Fixed-point constants, register index codes, arctangent table, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package ddodo_pkg;

  typedef logic signed [31:0] q16_t;   // Q16.16 signed word
  typedef logic signed [65:0] prod_t;  // full product of the shared multiplier

  // register index codes (word address bits [3:2])
  localparam logic [1:0] REG_DIST    = 2'd0;
  localparam logic [1:0] REG_HEADING = 2'd1;
  localparam logic [1:0] REG_SPEED   = 2'd2;
  localparam logic [1:0] REG_ANGLE   = 2'd3;

  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam logic signed [31:0] QUARTER_TURN    = 32'sd1073741824;
  localparam logic signed [31:0] DEG180_Q16      = 32'sd11796480;
  localparam logic signed [31:0] DEG360_Q16      = 32'sd23592960;

  localparam prod_t SAT_HI = 66'sd2147483647;
  localparam prod_t SAT_LO = -66'sd2147483648;

  // divide-by-ten unit: 36-bit dividend, 4 quotient bits per cycle
  localparam int DIV_DIGITS = 4;
  localparam int DIV_CYCLES = 9;

  function automatic q16_t sat32(input prod_t v);
    if (v > SAT_HI) begin
      return 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // fold a wheel angle back into +/-180 degrees
  function automatic q16_t wrap_angle(input q16_t a);
    if (a > DEG180_Q16) begin
      return a - DEG360_Q16;
    end else if (a < -DEG180_Q16) begin
      return a + DEG360_Q16;
    end else begin
      return a;
    end
  endfunction

  // atan(2^-i) in binary angle units
  function automatic logic signed [31:0] atan_q(input logic [4:0] i);
    case (i)
      5'd0:  return 32'sd536870912;
      5'd1:  return 32'sd316933406;
      5'd2:  return 32'sd167458907;
      5'd3:  return 32'sd85004756;
      5'd4:  return 32'sd42667331;
      5'd5:  return 32'sd21354465;
      5'd6:  return 32'sd10679838;
      5'd7:  return 32'sd5340245;
      5'd8:  return 32'sd2670163;
      5'd9:  return 32'sd1335087;
      5'd10: return 32'sd667544;
      5'd11: return 32'sd333772;
      5'd12: return 32'sd166886;
      5'd13: return 32'sd83443;
      5'd14: return 32'sd41722;
      5'd15: return 32'sd20861;
      5'd16: return 32'sd10430;
      5'd17: return 32'sd5215;
      5'd18: return 32'sd2608;
      5'd19: return 32'sd1304;
      5'd20: return 32'sd652;
      5'd21: return 32'sd326;
      5'd22: return 32'sd163;
      5'd23: return 32'sd81;
      5'd24: return 32'sd41;
      5'd25: return 32'sd20;
      5'd26: return 32'sd10;
      5'd27: return 32'sd5;
      5'd28: return 32'sd3;
      5'd29: return 32'sd1;
      5'd30: return 32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ hdl/differential_drive_odometry_unit.sv @@
// ----------------------------------------------------------------------------
// differential_drive_odometry_unit: dead-reckoning odometry for a two-wheel base
// Per tick: wheel speeds, travel, heading update, CORDIC sin/cos, position step.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  in      | in_valid / in_stall    | operation count_left count_right hold
//          |                        | new_x new_y new_heading
//  out     | out_valid / out_stall  | pos_x pos_y heading travel speed_left
//          |                        | speed_right wheel_angle_left/right
//  cfg     | APB psel/penable/pready| paddr pwdata prdata, 4 regs at 4*i
//
// From accept to the next accept an odometry tick passes through the shared
// 33x33 multiplier, the CORDIC at one cycle per iteration, the multiplier
// again for the position products and the divide-by-ten unit, and then the
// apply and final states. A pose load goes straight to the final state.
// Reset (rst, synchronous) clears registers, pose and wheel angles.
// in_stall is high while a beat is being worked on. The result beat sits
// in the output register; a new input beat is taken while it waits, and
// the unit only holds in its final state if the previous result is unread.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry_unit #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input beats
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic signed [15:0] count_left,
  input  logic signed [15:0] count_right,
  input  logic               hold,
  input  logic signed [31:0] new_x,
  input  logic signed [31:0] new_y,
  input  logic [31:0]        new_heading,
  // result beats
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [31:0]        heading,
  output logic signed [31:0] travel,
  output logic signed [31:0] speed_left,
  output logic signed [31:0] speed_right,
  output logic signed [31:0] wheel_angle_left,
  output logic signed [31:0] wheel_angle_right
);

  localparam int CW = $clog2(CORDIC_STEPS);
  localparam logic [CW-1:0] CORDIC_LAST = CW'(CORDIC_STEPS - 1);
  localparam logic [CW-1:0] DIV_LAST    = CW'(ddodo_pkg::DIV_CYCLES - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;  // speeds, travel, heading, wheels
  localparam logic [2:0] ST_CORDIC = 3'd2;
  localparam logic [2:0] ST_PROD   = 3'd3;  // travel * sin, travel * cos
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_APPLY  = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0]    state;
  logic [CW-1:0] cnt;

  // configuration registers
  logic [31:0] dist_per_count;
  logic [31:0] heading_per_count;
  logic [31:0] speed_per_count;
  logic [31:0] angle_per_count;

  // pose and wheel state
  ddodo_pkg::q16_t x_store;
  ddodo_pkg::q16_t y_store;
  logic [31:0]     hd_store;
  ddodo_pkg::q16_t left_angle_store;
  ddodo_pkg::q16_t right_angle_store;

  // per-beat working registers
  logic               op_r;
  logic               hold_r;
  logic signed [16:0] lc;   // negated left count
  logic signed [16:0] rc;
  ddodo_pkg::q16_t    trv;
  ddodo_pkg::q16_t    spl;
  ddodo_pkg::q16_t    spr;
  ddodo_pkg::q16_t    wa;   // wrapped wheel angle feeding the next add

  // CORDIC
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] cz;
  logic               flip_r;

  // divide by ten, x and y side by side
  logic [35:0] qx;
  logic [35:0] qy;
  logic [3:0]  rx;
  logic [3:0]  ry;
  logic        neg_x;
  logic        neg_y;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  ddodo_pkg::prod_t   mul_p;
  ddodo_pkg::prod_t   prod_abs;

  logic signed [17:0] sum_rl;
  logic signed [17:0] dif_rl;
  logic signed [31:0] hd_signed;
  logic               flip;
  logic signed [31:0] cdx;
  logic signed [31:0] cdy;
  logic signed [31:0] catan;
  logic [39:0]        divx_next;
  logic [39:0]        divy_next;
  ddodo_pkg::prod_t   px;
  ddodo_pkg::prod_t   py;
  logic               in_take;

  // four restoring steps of a division by ten
  function automatic logic [39:0] div10_step(input logic [3:0] r_in, input logic [35:0] q_in);
    logic [4:0]  r5;
    logic [3:0]  r;
    logic [35:0] q;
    r = r_in;
    q = q_in;
    for (int k = 0; k < ddodo_pkg::DIV_DIGITS; k++) begin
      r5 = {r, q[35]};
      q  = {q[34:0], 1'b0};
      if (r5 >= 5'd10) begin
        r5   = r5 - 5'd10;
        q[0] = 1'b1;
      end
      r = r5[3:0];
    end
    return {r, q};
  endfunction

  assign pready   = 1'b1;
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    case (paddr[3:2])
      ddodo_pkg::REG_DIST:    prdata = dist_per_count;
      ddodo_pkg::REG_HEADING: prdata = heading_per_count;
      ddodo_pkg::REG_SPEED:   prdata = speed_per_count;
      ddodo_pkg::REG_ANGLE:   prdata = angle_per_count;
      default:                prdata = 32'd0;
    endcase
  end

  assign sum_rl = {rc[16], rc} + {lc[16], lc};
  assign dif_rl = {rc[16], rc} - {lc[16], lc};

  // operand select: one product per cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL: begin
        case (cnt)
          CW'(0): begin
            mul_a = {{16{rc[16]}}, rc};
            mul_b = {1'b0, speed_per_count};
          end
          CW'(1): begin
            mul_a = {{16{lc[16]}}, lc};
            mul_b = {1'b0, speed_per_count};
          end
          CW'(2): begin
            mul_a = {{15{sum_rl[17]}}, sum_rl};
            mul_b = {1'b0, dist_per_count};
          end
          CW'(3): begin
            mul_a = {{15{dif_rl[17]}}, dif_rl};
            mul_b = {1'b0, heading_per_count};
          end
          CW'(4): begin
            mul_a = {{16{rc[16]}}, rc};
            mul_b = {1'b0, angle_per_count};
          end
          CW'(5): begin
            mul_a = {{16{lc[16]}}, lc};
            mul_b = {1'b0, angle_per_count};
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_PROD: begin
        mul_a = {trv[31], trv};
        if (cnt == CW'(0)) begin
          mul_b = {cy[31], cy};
        end else begin
          mul_b = {cx[31], cx};
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_abs = mul_p[65] ? -mul_p : mul_p;

  // CORDIC argument reduction to +/- a quarter turn
  assign hd_signed = hd_store;
  assign flip = (hd_signed > ddodo_pkg::QUARTER_TURN) || (hd_signed < -ddodo_pkg::QUARTER_TURN);

  assign cdx   = cy >>> cnt;
  assign cdy   = cx >>> cnt;
  assign catan = ddodo_pkg::atan_q(5'(cnt));

  assign divx_next = div10_step(rx, qx);
  assign divy_next = div10_step(ry, qy);

  // steps are truncated toward zero: sign applied to the magnitude quotient
  assign px = {{34{x_store[31]}}, x_store} + (neg_x ? -{30'd0, qx} : {30'd0, qx});
  assign py = {{34{y_store[31]}}, y_store} - (neg_y ? -{30'd0, qy} : {30'd0, qy});

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_count    <= 32'd0;
      heading_per_count <= 32'd0;
      speed_per_count   <= 32'd0;
      angle_per_count   <= 32'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        ddodo_pkg::REG_DIST:    dist_per_count    <= pwdata;
        ddodo_pkg::REG_HEADING: heading_per_count <= pwdata;
        ddodo_pkg::REG_SPEED:   speed_per_count   <= pwdata;
        ddodo_pkg::REG_ANGLE:   angle_per_count   <= pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      cnt               <= '0;
      out_valid         <= 1'b0;
      x_store           <= '0;
      y_store           <= '0;
      hd_store          <= '0;
      left_angle_store  <= '0;
      right_angle_store <= '0;
    end else begin
      // in the final state the reload below owns out_valid
      if (out_valid && !out_stall && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            op_r   <= operation;
            hold_r <= hold;
            lc     <= -{count_left[15], count_left};
            rc     <= {count_right[15], count_right};
            cnt    <= '0;
            if (operation) begin
              x_store  <= new_x;
              y_store  <= new_y;
              hd_store <= new_heading;
              trv      <= '0;
              spl      <= '0;
              spr      <= '0;
              state    <= ST_FIN;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          // each cycle retires the product selected the cycle before
          case (cnt)
            CW'(1): spr <= ddodo_pkg::sat32(mul_p);
            CW'(2): spl <= ddodo_pkg::sat32(mul_p);
            CW'(3): trv <= ddodo_pkg::sat32(mul_p >>> 17);
            CW'(4): hd_store <= hd_store + mul_p[31:0];
            CW'(5): begin
              if (!hold_r) begin
                right_angle_store <= ddodo_pkg::sat32({{34{wa[31]}}, wa} + mul_p);
              end
            end
            CW'(6): begin
              if (!hold_r) begin
                left_angle_store <= ddodo_pkg::sat32({{34{wa[31]}}, wa} + mul_p);
              end
            end
            default: ;
          endcase
          if (cnt == CW'(4)) begin
            wa <= ddodo_pkg::wrap_angle(right_angle_store);
          end else if (cnt == CW'(5)) begin
            wa <= ddodo_pkg::wrap_angle(left_angle_store);
          end
          if (cnt == CW'(6)) begin
            // heading is final here: seed the CORDIC
            cx     <= ddodo_pkg::CORDIC_GAIN_Q30;
            cy     <= '0;
            cz     <= flip ? {~hd_store[31], hd_store[30:0]} : hd_store;
            flip_r <= flip;
            cnt    <= '0;
            state  <= ST_CORDIC;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_CORDIC: begin
          if (!cz[31]) begin
            cx <= cx - cdx;
            cy <= cy + cdy;
            cz <= cz - catan;
          end else begin
            cx <= cx + cdx;
            cy <= cy - cdy;
            cz <= cz + catan;
          end
          if (cnt == CORDIC_LAST) begin
            cnt   <= '0;
            state <= ST_PROD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_PROD: begin
          // a half-turn fold negates sin and cos, so it just flips the sign
          if (cnt == CW'(1)) begin
            qx    <= prod_abs[65:30];
            rx    <= '0;
            neg_x <= mul_p[65] ^ flip_r;
          end
          if (cnt == CW'(2)) begin
            qy    <= prod_abs[65:30];
            ry    <= '0;
            neg_y <= mul_p[65] ^ flip_r;
            cnt   <= '0;
            state <= ST_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          {rx, qx} <= divx_next;
          {ry, qy} <= divy_next;
          if (cnt == DIV_LAST) begin
            cnt   <= '0;
            state <= ST_APPLY;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_APPLY: begin
          x_store <= ddodo_pkg::sat32(px);
          y_store <= ddodo_pkg::sat32(py);
          state   <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || !out_stall) begin
            pos_x             <= x_store;
            pos_y             <= y_store;
            heading           <= hd_store;
            travel            <= trv;
            speed_left        <= spl;
            speed_right       <= spr;
            wheel_angle_left  <= left_angle_store;
            wheel_angle_right <= right_angle_store;
            out_valid         <= 1'b1;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // an accepted beat always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state != ST_IDLE))
    else $error("accepted beat did not start work");

  // a pose load reports zero travel and speeds
  a_pose_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && op_r && (!out_valid || !out_stall))
      |=> (travel == 0 && speed_left == 0 && speed_right == 0))
    else $error("pose load result carries motion");

  // hold freezes both wheel angle accumulators
  a_hold_freeze: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL && hold_r)
      |=> ($stable(left_angle_store) && $stable(right_angle_store)))
    else $error("wheel angle moved under hold");

  // the result register only reloads once the previous beat is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_valid && out_stall) |=> (state == ST_FIN))
    else $error("finished while output beat pending");

endmodule

`default_nettype wire

@@ dv/ddodo_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddodo_tb_pkg: shared testbench types for the odometry unit
// Beat operation codes and the packed layout of one expected result beat.
// ----------------------------------------------------------------------------

package ddodo_tb_pkg;

  typedef enum logic {
    OP_TICK      = 1'b0,
    OP_LOAD_POSE = 1'b1
  } odo_op_e;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic [31:0] travel;
    logic [31:0] speed_left;
    logic [31:0] speed_right;
    logic [31:0] wheel_left;
    logic [31:0] wheel_right;
  } pose_report_t;

endpackage

@@ dv/differential_drive_odometry_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_checker: pose predictor and result scoreboard
// Shadows the gain registers from the APB port, predicts each result beat
// from accepted input beats and compares result beats in order.
// ----------------------------------------------------------------------------

module differential_drive_odometry_checker #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               operation,
  input  logic signed [15:0] count_left,
  input  logic signed [15:0] count_right,
  input  logic               hold,
  input  logic signed [31:0] new_x,
  input  logic signed [31:0] new_y,
  input  logic [31:0]        new_heading,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [31:0]        heading,
  input  logic signed [31:0] travel,
  input  logic signed [31:0] speed_left,
  input  logic signed [31:0] speed_right,
  input  logic signed [31:0] wheel_angle_left,
  input  logic signed [31:0] wheel_angle_right,
  output int                 errors,
  output int                 pending,
  output int                 checked
);

  localparam longint GAIN_Q30  = 64'sd652032874;
  localparam longint QUARTER   = 64'sd1073741824;
  localparam longint HALF      = 64'sd2147483648;
  localparam longint HALF_DEG  = 64'sd180 * 64'sd65536;
  localparam longint FULL_DEG  = 64'sd360 * 64'sd65536;
  localparam longint STEP_DIV  = 64'sd10 * 64'sd1073741824;

  longint arctan_steps [0:31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  // gain shadows
  logic [31:0] dist_k, turn_k, rpm_k, deg_k;
  // pose and wheel state
  logic signed [31:0] x_pos, y_pos, left_deg, right_deg;
  logic [31:0]        bearing;

  ddodo_tb_pkg::pose_report_t want_q[$];
  ddodo_tb_pkg::pose_report_t want, got;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic flag(input string what, input logic [31:0] seen,
                      input logic [31:0] exp_val);
    errors++;
    $display("[%0t] %s: got %h, want %h", $time, what, seen, exp_val);
  endtask

  task automatic cmp(input string what, input logic [31:0] seen,
                     input logic [31:0] exp_val);
    if (seen !== exp_val) flag(what, seen, exp_val);
  endtask

  // Q1.30 cos/sin of a binary angle, quadrants 2/3 folded by a half turn
  function automatic void sin_cos(input logic [31:0] ang, output longint cs,
                                  output longint sn);
    longint z, cx, cy, dx, dy;
    bit     flip;
    z    = longint'($signed(ang));
    cx   = GAIN_Q30;
    cy   = 0;
    flip = 1'b0;
    if (z > QUARTER) begin
      z    = z - HALF;
      flip = 1'b1;
    end else if (z < -QUARTER) begin
      z    = z + HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        z  = z - arctan_steps[i];
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        z  = z + arctan_steps[i];
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    cs = cx;
    sn = cy;
  endfunction

  // fold into +/-180 deg first, then add the counts, saturating
  function automatic logic signed [31:0] wheel_step(input logic signed [31:0] st,
                                                    input longint counts);
    longint a;
    a = st;
    if (a > HALF_DEG) a = a - FULL_DEG;
    else if (a < -HALF_DEG) a = a + FULL_DEG;
    a = clamp32(a + counts * longint'(deg_k));
    return 32'(a);
  endfunction

  function automatic ddodo_tb_pkg::pose_report_t predict(input logic op,
                                           input logic signed [15:0] cl,
                                           input logic signed [15:0] cr,
                                           input logic hd,
                                           input logic signed [31:0] nx,
                                           input logic signed [31:0] ny,
                                           input logic [31:0] nh);
    ddodo_tb_pkg::pose_report_t r;
    longint lc, rc, cs, sn, trav, spl, spr, px, py;
    logic [31:0] diff;
    trav = 0;
    spl  = 0;
    spr  = 0;
    if (op == ddodo_tb_pkg::OP_LOAD_POSE) begin
      x_pos   = nx;
      y_pos   = ny;
      bearing = nh;
    end else begin
      lc = -longint'(cl);   // left wheel counts backwards
      rc = longint'(cr);
      if (!hd) begin
        right_deg = wheel_step(right_deg, rc);
        left_deg  = wheel_step(left_deg, lc);
      end
      spr  = clamp32(rc * longint'(rpm_k));
      spl  = clamp32(lc * longint'(rpm_k));
      trav = clamp32(((rc + lc) * longint'(dist_k)) >>> 17);
      diff = 32'(rc - lc);
      bearing = bearing + diff * turn_k;
      sin_cos(bearing, cs, sn);
      px = longint'(x_pos) + (trav * sn) / STEP_DIV;
      py = longint'(y_pos) - (trav * cs) / STEP_DIV;
      x_pos = 32'(clamp32(px));
      y_pos = 32'(clamp32(py));
    end
    r.pos_x       = x_pos;
    r.pos_y       = y_pos;
    r.heading     = bearing;
    r.travel      = 32'(trav);
    r.speed_left  = 32'(spl);
    r.speed_right = 32'(spr);
    r.wheel_left  = left_deg;
    r.wheel_right = right_deg;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      dist_k    = '0;
      turn_k    = '0;
      rpm_k     = '0;
      deg_k     = '0;
      x_pos     = '0;
      y_pos     = '0;
      bearing   = '0;
      left_deg  = '0;
      right_deg = '0;
      errors    = 0;
      checked   = 0;
      want_q.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            ddodo_pkg::REG_DIST:    dist_k = pwdata;
            ddodo_pkg::REG_HEADING: turn_k = pwdata;
            ddodo_pkg::REG_SPEED:   rpm_k  = pwdata;
            ddodo_pkg::REG_ANGLE:   deg_k  = pwdata;
            default: ;
          endcase
        end else begin
          case (paddr[3:2])
            ddodo_pkg::REG_DIST:    cmp("readback dist_per_count", prdata, dist_k);
            ddodo_pkg::REG_HEADING: cmp("readback heading_per_count", prdata, turn_k);
            ddodo_pkg::REG_SPEED:   cmp("readback speed_per_count", prdata, rpm_k);
            ddodo_pkg::REG_ANGLE:   cmp("readback angle_per_count", prdata, deg_k);
            default: ;
          endcase
        end
      end
      // result side first: a result never belongs to a beat taken this edge
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          flag("result beat with none outstanding", pos_x, '0);
        end else begin
          want = want_q.pop_front();
          got  = '{pos_x, pos_y, heading, travel, speed_left, speed_right,
                   wheel_angle_left, wheel_angle_right};
          cmp("pos_x", got.pos_x, want.pos_x);
          cmp("pos_y", got.pos_y, want.pos_y);
          cmp("heading", got.heading, want.heading);
          cmp("travel", got.travel, want.travel);
          cmp("speed_left", got.speed_left, want.speed_left);
          cmp("speed_right", got.speed_right, want.speed_right);
          cmp("wheel_angle_left", got.wheel_left, want.wheel_left);
          cmp("wheel_angle_right", got.wheel_right, want.wheel_right);
          checked++;
        end
      end
      if (in_valid && !in_stall) begin
        want_q.push_back(predict(operation, count_left, count_right, hold,
                                 new_x, new_y, new_heading));
      end
      pending <= want_q.size();
    end
  end

endmodule

@@ dv/differential_drive_odometry_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_unit_tb: top of the odometry unit testbench
// Drives gain writes and readbacks, a directed set of tick and pose-load beats,
// then random phases under several gain settings with random idling on both
// channels; the checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------

module differential_drive_odometry_unit_tb;

  localparam int CORDIC_STEPS    = 24;
  localparam int PHASES          = 8;
  localparam int BEATS_PER_PHASE = 150;
  localparam int IDLE_PCT        = 35;
  localparam int PARK_CYCLES     = 300;   // receiver hold-off, fills the unit
  localparam int SETTLE_CYCLES   = 4;     // every beat yields a result
  localparam int TAIL_CYCLES     = 60;    // longer than one tick
  localparam int QUIET_LIMIT     = 4000;  // > park + a tick, many times over

  logic               clk;
  logic               rst         = 1'b1;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [3:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic               operation   = 1'b0;
  logic signed [15:0] count_left  = '0;
  logic signed [15:0] count_right = '0;
  logic               hold        = 1'b0;
  logic signed [31:0] new_x       = '0;
  logic signed [31:0] new_y       = '0;
  logic [31:0]        new_heading = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic signed [31:0] pos_x, pos_y, travel, speed_left, speed_right;
  logic signed [31:0] wheel_angle_left, wheel_angle_right;
  logic [31:0]        heading;

  int errors, pending, checked;

  // stimulus controls and tallies
  logic calm      = 1'b0;  // no idling on either side while set
  int   park_reqs = 0;     // bumped to ask the receiver for a long hold-off
  int   n_ticks   = 0;
  int   n_held    = 0;
  int   n_loads   = 0;
  int   n_gains   = 0;

  differential_drive_odometry_unit #(.CORDIC_STEPS(CORDIC_STEPS)) u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .count_left(count_left), .count_right(count_right), .hold(hold),
    .new_x(new_x), .new_y(new_y), .new_heading(new_heading),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading), .travel(travel),
    .speed_left(speed_left), .speed_right(speed_right),
    .wheel_angle_left(wheel_angle_left), .wheel_angle_right(wheel_angle_right)
  );

  differential_drive_odometry_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .count_left(count_left), .count_right(count_right), .hold(hold),
    .new_x(new_x), .new_y(new_y), .new_heading(new_heading),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading), .travel(travel),
    .speed_left(speed_left), .speed_right(speed_right),
    .wheel_angle_left(wheel_angle_left), .wheel_angle_right(wheel_angle_right),
    .errors(errors), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --- APB access: setup cycle, then access until pready -------------------
  // Each access ends only after an edge with psel low, so back-to-back calls never
  // lower and raise psel in the same step.
  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write all four gains, then read them back (checker compares prdata)
  task automatic set_gains(input logic [31:0] d, input logic [31:0] h,
                           input logic [31:0] s, input logic [31:0] a);
    apb_access(1'b1, ddodo_pkg::REG_DIST, d);
    apb_access(1'b1, ddodo_pkg::REG_HEADING, h);
    apb_access(1'b1, ddodo_pkg::REG_SPEED, s);
    apb_access(1'b1, ddodo_pkg::REG_ANGLE, a);
    apb_access(1'b0, ddodo_pkg::REG_DIST, '0);
    apb_access(1'b0, ddodo_pkg::REG_HEADING, '0);
    apb_access(1'b0, ddodo_pkg::REG_SPEED, '0);
    apb_access(1'b0, ddodo_pkg::REG_ANGLE, '0);
    n_gains++;
  endtask

  // --- input beats ----------------------------------------------------------
  // Random idle cycles go in front of a beat; with no gap valid simply stays
  // high and only the payload changes.
  task automatic idle_gap();
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_beat(input ddodo_tb_pkg::odo_op_e op,
                           input logic signed [15:0] cl,
                           input logic signed [15:0] cr, input logic hd,
                           input logic [31:0] nx, input logic [31:0] ny,
                           input logic [31:0] nh);
    idle_gap();
    in_valid    <= 1'b1;
    operation   <= op;
    count_left  <= cl;
    count_right <= cr;
    hold        <= hd;
    new_x       <= nx;
    new_y       <= ny;
    new_heading <= nh;
    do @(posedge clk); while (in_stall);
    if (op == ddodo_tb_pkg::OP_LOAD_POSE) begin
      n_loads++;
    end else begin
      n_ticks++;
      if (hd) n_held++;
    end
  endtask

  task automatic tick(input logic signed [15:0] cl, input logic signed [15:0] cr,
                      input logic hd);
    send_beat(ddodo_tb_pkg::OP_TICK, cl, cr, hd, $urandom(), $urandom(), $urandom());
  endtask

  task automatic load_pose(input logic [31:0] nx, input logic [31:0] ny,
                           input logic [31:0] nh);
    send_beat(ddodo_tb_pkg::OP_LOAD_POSE, 16'($urandom()), 16'($urandom()),
              1'($urandom()), nx, ny, nh);
  endtask

  // stop offering, wait for every outstanding result, then a short settle;
  // pending is registered, so the first edge is always waited out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --- random content -------------------------------------------------------
  function automatic logic signed [15:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'(int'($urandom_range(600)) - 300);
    if (r < 85) return 16'($urandom());
    case ($urandom_range(3))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_coord();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return {{8{r[23]}}, r[23:0]};   // within +/-128 m
      default: return r;
    endcase
  endfunction

  // quarter-turn boundaries +/-1 are where the CORDIC folds
  function automatic logic [31:0] pick_bearing();
    if ($urandom_range(99) < 30) begin
      return {2'($urandom_range(3)), 30'd0} + 32'(int'($urandom_range(2)) - 1);
    end
    return $urandom();
  endfunction

  // gain: zero, full scale, realistic, or anything
  function automatic logic [31:0] pick_gain(input logic [31:0] typical);
    case ($urandom_range(3))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(typical);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_beat();
    logic signed [15:0] cl, cr;
    logic               hd;
    cr = pick_count();
    // many ticks drive straight (left = -right) so heading stays put
    cl = ($urandom_range(99) < 40) ? -cr : pick_count();
    hd = ($urandom_range(99) < 25);
    if ($urandom_range(99) < 10) begin
      send_beat(ddodo_tb_pkg::OP_LOAD_POSE, cl, cr, hd, pick_coord(), pick_coord(),
                pick_bearing());
    end else begin
      tick(cl, cr, hd);
    end
  endtask

  // --- receiver: random stalls, plus one long hold-off on request ----------
  initial begin : result_sink
    int parks_done;
    parks_done = 0;
    forever begin
      @(posedge clk);
      if (park_reqs != parks_done) begin
        parks_done++;
        out_stall <= 1'b1;
        repeat (PARK_CYCLES) @(posedge clk);
      end
      out_stall <= (!calm && $urandom_range(99) < IDLE_PCT);
    end
  end

  // --- watchdog: cycles without any handshake -------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
    $display("differential_drive_odometry_unit: mismatch");
    $finish;
  end

  // --- stimulus and verdict -------------------------------------------------
  initial begin : stimulus
    int ph, k;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: ~0.004 m/count, small turn gain, 10 rpm/count, 1 deg/count
    set_gains(32'h0100_0000, 32'h0010_0000, 32'h000A_0000, 32'h0001_0000);
    tick(16'sd0, 16'sd0, 1'b0);
    tick(-16'sd32768, 16'sd32767, 1'b0);       // full speed straight ahead
    tick(16'sd32767, -16'sd32768, 1'b0);       // full speed straight back
    tick(16'sd32767, 16'sd32767, 1'b0);        // spin in place
    tick(-16'sd32768, -16'sd32768, 1'b0);
    tick(-16'sd1000, 16'sd1000, 1'b1);         // wheel angles frozen
    // x pushed past its top while facing a quarter turn
    load_pose(32'h7FFF_0000, 32'h8001_0000, 32'h4000_0000);
    tick(-16'sd32768, 16'sd32767, 1'b0);
    // just past the quarter-turn fold, both signs
    load_pose(32'h0000_0000, 32'h0000_0000, 32'h4000_0001);
    tick(-16'sd500, 16'sd500, 1'b0);
    load_pose(32'h0000_0000, 32'h0000_0000, 32'hC000_0000);
    tick(-16'sd500, 16'sd500, 1'b0);
    load_pose(32'h0000_0000, 32'h0000_0000, 32'hBFFF_FFFF);
    tick(-16'sd500, 16'sd500, 1'b0);
    // half turn: y grows into its top, x at its bottom
    load_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    tick(-16'sd32768, 16'sd32767, 1'b0);
    load_pose(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    // wheel angles well past 180 deg: fold, then saturate
    tick(-16'sd20000, 16'sd20000, 1'b0);
    tick(-16'sd20000, 16'sd20000, 1'b0);
    tick(16'sd20000, -16'sd20000, 1'b0);
    tick(-16'sd32768, 16'sd32767, 1'b0);
    tick(16'sd0, 16'sd0, 1'b1);

    for (ph = 0; ph < PHASES; ph++) begin
      drain();   // gains change only with the unit idle
      case (ph)
        0:       set_gains('0, '0, '0, '0);
        1:       set_gains('1, '1, '1, '1);
        default: set_gains(pick_gain(32'h0100_0000), pick_gain(32'h0040_0000),
                           pick_gain(32'h0010_0000), pick_gain(32'h0004_0000));
      endcase
      calm <= (ph == 2);   // one phase with no idling at all
      for (k = 0; k < BEATS_PER_PHASE; k++) begin
        if (ph == 3 && k == 40) park_reqs <= park_reqs + 1;  // fill the unit
        if (ph == 4 && k == 75) drain();                     // sender pause
        random_beat();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d ticks (%0d held), %0d pose loads under %0d gain settings",
             n_ticks, n_held, n_loads, n_gains);
    $display("%0d result beats compared, long receiver hold-off and drain pause done",
             checked);
    if (errors == 0 && pending == 0) begin
      $display("differential_drive_odometry_unit: match");
    end else begin
      $display("differential_drive_odometry_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ differential_drive_odometry_unit.f @@
hdl/ddodo_pkg.sv
hdl/differential_drive_odometry_unit.sv
dv/ddodo_tb_pkg.sv
dv/differential_drive_odometry_checker.sv
dv/differential_drive_odometry_unit_tb.sv
